>>> sv/prp_pkg.sv
// Shared constants, codes and divider handshake types for the PageRank engine.
// No dependencies; imported by every module of the block.
package prp_pkg;

	localparam int MAX_NODES = 4096;
	localparam int NODE_W    = 12;
	localparam int NCNT_W    = 13;
	localparam int EDGE_AW   = 16;
	localparam int ECNT_W    = 17;
	localparam int DEG_W     = 17;
	localparam int RANK_W    = 32;
	localparam int SUM_W     = 48;
	localparam int L1_W      = 34;
	localparam int DIV_W     = 33;
	localparam int DIV_CNT_W = 6;

	localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
	localparam logic [1:0] REQ_RUN      = 2'd1;
	localparam logic [1:0] REQ_READ     = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [1:0] CFG_MAX_ITER   = 2'd1;
	localparam logic [1:0] CFG_DAMPING    = 2'd2;
	localparam logic [1:0] CFG_EPSILON    = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> sv/prp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on prp_pkg for widths and the request/response structs.
module prp_div import prp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]     dq_q;
	logic [DEG_W-1:0]     dsr_q;
	logic [DEG_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEG_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dq_q   <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// quotient bits shift in from the bottom as dividend bits leave the top
				rem_q <= fits ? DEG_W'(trial - {1'b0, dsr_q}) : trial[DEG_W-1:0];
				dq_q  <= {dq_q[DIV_W-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule

>>> sv/pagerank_power_iteration_top.sv
// PageRank power-iteration engine: edge store, degree/rank memories, run sequencer.
// Depends on prp_pkg and prp_div.
//
// Usage: one request transaction on the input channel (in_valid/in_stall) gives
// exactly one result transaction on the output channel (out_valid/out_stall).
// Configuration registers are written over cfg_valid/cfg_ready (always ready);
// the user must write them only while the engine is idle, which the block itself
// does not enforce. Index 0 node_count, 1 max_iterations, 2 damping, 3 epsilon.
// An add-edge or read request passes through ST_EDGE_WR or ST_READ_WAIT, then
// ST_RESULT, before out_valid; an unknown or rejected request goes straight to
// ST_RESULT. The next request is taken once the engine is back in ST_IDLE.
// A run does two setup divisions, then per iteration a node pass that divides
// each rank by its nonzero out-degree, an edge pass and a node update pass; the
// divider that forms each node's outgoing share takes most of a run's time.
// One request is processed at a time; in_stall is high while one is in work.
// A finished result sits in the output register, so the next request is taken
// while a result waits; if the receiver stalls, the following result holds
// the engine until the output register frees.
// After reset the degree and rank memories are cleared, one entry per cycle,
// with in_stall high until every entry is clear. Ranks read zero until a run.
module pagerank_power_iteration_top import prp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [NODE_W-1:0]   from_node,
	input  logic [NODE_W-1:0]   to_node,
	input  logic [NODE_W-1:0]   query_node,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [RANK_W-1:0]   rank_value,
	output logic [9:0]          iterations_done,
	output logic [L1_W-1:0]     l1_error,
	output logic                converged,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_EDGE_WR, ST_READ_WAIT, ST_DIV_U, ST_DIV_B,
		ST_C_RD, ST_C_LD, ST_C_DIV, ST_E_RD, ST_E_CHK, ST_E_ACC,
		ST_N_RD, ST_N_MUL, ST_N_ACC, ST_ITER_END, ST_RESULT
	} state_t;

	state_t               state_q;
	logic [NCNT_W-1:0]    node_count_q;
	logic [9:0]           max_iter_q;
	logic [15:0]          damping_q;
	logic [31:0]          epsilon_q;

	logic [ECNT_W-1:0]    edge_total_q;
	logic [NODE_W-1:0]    clr_idx_q;
	logic [NODE_W-1:0]    idx_q;
	logic [EDGE_AW-1:0]   eidx_q;
	logic [NODE_W-1:0]    from_q;
	logic [NODE_W-1:0]    dst_q;
	logic [9:0]           iter_q;
	logic                 first_q;
	logic [RANK_W-1:0]    uniform_q;
	logic [RANK_W-1:0]    base_q;
	logic [L1_W-1:0]      err_q;
	logic [SUM_W-1:0]     prod_hi_q;
	logic [15:0]          prod_lo_q;
	logic [RANK_W-1:0]    prev_q;

	logic [1:0]           pend_status_q;
	logic [RANK_W-1:0]    pend_rank_q;
	logic [9:0]           pend_iter_q;
	logic [L1_W-1:0]      pend_err_q;
	logic                 pend_conv_q;

	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [RANK_W-1:0]    out_rank_q;
	logic [9:0]           out_iter_q;
	logic [L1_W-1:0]      out_err_q;
	logic                 out_conv_q;

	// memories
	logic [2*NODE_W-1:0]  edge_mem [2**EDGE_AW];
	logic [DEG_W-1:0]     deg_mem [MAX_NODES];
	logic [RANK_W-1:0]    rank_mem [MAX_NODES];
	logic [RANK_W-1:0]    contrib_mem [MAX_NODES];
	logic [SUM_W-1:0]     insum_mem [MAX_NODES];

	logic                 edge_we;
	logic [EDGE_AW-1:0]   edge_addr;
	logic [2*NODE_W-1:0]  edge_rdata;
	logic                 deg_we;
	logic [NODE_W-1:0]    deg_waddr, deg_raddr;
	logic [DEG_W-1:0]     deg_wdata, deg_rdata;
	logic                 rank_we;
	logic [NODE_W-1:0]    rank_waddr, rank_raddr;
	logic [RANK_W-1:0]    rank_wdata, rank_rdata;
	logic                 contrib_we;
	logic [NODE_W-1:0]    contrib_waddr, contrib_raddr;
	logic [RANK_W-1:0]    contrib_wdata, contrib_rdata;
	logic                 insum_we;
	logic [NODE_W-1:0]    insum_waddr, insum_raddr;
	logic [SUM_W-1:0]     insum_wdata, insum_rdata;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic                 in_fire;
	logic                 from_ok, to_ok, query_ok, run_ok;
	logic                 out_free;
	logic                 last_node, last_edge;
	logic [NODE_W-1:0]    e_src, e_dst;
	logic                 e_ok;
	logic [RANK_W-1:0]    c_prev;
	logic [SUM_W:0]       acc_sum;
	logic [SUM_W-1:0]     acc_sat;
	logic [SUM_W:0]       term;
	logic [RANK_W-1:0]    term_sat;
	logic [RANK_W:0]      v_sum;
	logic [RANK_W-1:0]    v_new;
	logic [RANK_W-1:0]    diff;
	logic [L1_W:0]        err_sum;
	logic [L1_W-1:0]      err_next;
	logic [RANK_W-1:0]    uni_cap, base_cap;
	logic [ECNT_W-1:0]    damp_comp;

	prp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign from_ok  = {1'b0, from_node} < node_count_q;
	assign to_ok    = {1'b0, to_node} < node_count_q;
	assign query_ok = {1'b0, query_node} < node_count_q;
	assign run_ok   = (node_count_q != '0) && (node_count_q <= NCNT_W'(MAX_NODES));

	assign last_node = {1'b0, idx_q} == node_count_q - 1'b1;
	assign last_edge = {1'b0, eidx_q} == edge_total_q - 1'b1;

	assign e_src = edge_rdata[2*NODE_W-1:NODE_W];
	assign e_dst = edge_rdata[NODE_W-1:0];
	assign e_ok  = ({1'b0, e_src} < node_count_q) && ({1'b0, e_dst} < node_count_q);

	assign c_prev = first_q ? uniform_q : rank_rdata;

	assign acc_sum = {1'b0, insum_rdata} + {{(SUM_W-RANK_W+1){1'b0}}, contrib_rdata};
	assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

	assign term     = {1'b0, prod_hi_q} + {{(SUM_W-15){1'b0}}, prod_lo_q};
	assign term_sat = (|term[SUM_W:RANK_W]) ? '1 : term[RANK_W-1:0];
	assign v_sum    = {1'b0, base_q} + {1'b0, term_sat};
	assign v_new    = v_sum[RANK_W] ? '1 : v_sum[RANK_W-1:0];
	assign diff     = (v_new > prev_q) ? v_new - prev_q : prev_q - v_new;
	assign err_sum  = {1'b0, err_q} + {{(L1_W-RANK_W+1){1'b0}}, diff};
	assign err_next = err_sum[L1_W] ? '1 : err_sum[L1_W-1:0];

	assign uni_cap   = div_rsp.quot[DIV_W-1] ? '1 : div_rsp.quot[RANK_W-1:0];
	assign base_cap  = uni_cap;
	assign damp_comp = ECNT_W'(17'h10000) - {1'b0, damping_q};

	// memory port control
	always_comb begin
		edge_we       = 1'b0;
		edge_addr     = eidx_q;
		deg_we        = 1'b0;
		deg_waddr     = idx_q;
		deg_wdata     = '0;
		deg_raddr     = idx_q;
		rank_we       = 1'b0;
		rank_waddr    = idx_q;
		rank_wdata    = v_new;
		rank_raddr    = idx_q;
		contrib_we    = 1'b0;
		contrib_waddr = idx_q;
		contrib_wdata = div_rsp.quot[RANK_W-1:0];
		contrib_raddr = e_src;
		insum_we      = 1'b0;
		insum_waddr   = idx_q;
		insum_wdata   = '0;
		insum_raddr   = idx_q;
		div_req       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				deg_we     = 1'b1;
				deg_waddr  = clr_idx_q;
				rank_we    = 1'b1;
				rank_waddr = clr_idx_q;
				rank_wdata = '0;
			end
			ST_IDLE: begin
				deg_raddr  = from_node;
				rank_raddr = query_node;
				if (in_fire && req_type == REQ_ADD_EDGE && from_ok && to_ok
						&& !edge_total_q[ECNT_W-1]) begin
					edge_we   = 1'b1;
					edge_addr = edge_total_q[EDGE_AW-1:0];
				end
				if (in_fire && req_type == REQ_RUN && run_ok) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(1) << RANK_W;
					div_req.divisor  = DEG_W'(node_count_q);
				end
			end
			ST_EDGE_WR: begin
				deg_we    = 1'b1;
				deg_waddr = from_q;
				deg_wdata = deg_rdata + 1'b1;
			end
			ST_DIV_U: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {damp_comp, 16'h0000};
					div_req.divisor  = DEG_W'(node_count_q);
				end
			end
			ST_C_LD: begin
				if (deg_rdata == '0) begin
					contrib_we    = 1'b1;
					contrib_wdata = '0;
					insum_we      = 1'b1;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {1'b0, c_prev};
					div_req.divisor  = deg_rdata;
				end
			end
			ST_C_DIV: begin
				if (div_rsp.done) begin
					contrib_we = 1'b1;
					insum_we   = 1'b1;
				end
			end
			ST_E_CHK: begin
				insum_raddr = e_dst;
			end
			ST_E_ACC: begin
				insum_we    = 1'b1;
				insum_waddr = dst_q;
				insum_wdata = acc_sat;
			end
			ST_N_ACC: begin
				rank_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_addr] <= {from_node, to_node};
		edge_rdata <= edge_mem[edge_addr];
	end

	always_ff @(posedge clk) begin
		if (deg_we)
			deg_mem[deg_waddr] <= deg_wdata;
		deg_rdata <= deg_mem[deg_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we)
			rank_mem[rank_waddr] <= rank_wdata;
		rank_rdata <= rank_mem[rank_raddr];
	end

	always_ff @(posedge clk) begin
		if (contrib_we)
			contrib_mem[contrib_waddr] <= contrib_wdata;
		contrib_rdata <= contrib_mem[contrib_raddr];
	end

	always_ff @(posedge clk) begin
		if (insum_we)
			insum_mem[insum_waddr] <= insum_wdata;
		insum_rdata <= insum_mem[insum_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_W'(1);
			max_iter_q   <= 10'd50;
			damping_q    <= 16'd55706;
			epsilon_q    <= 32'd4295;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data[NCNT_W-1:0];
				CFG_MAX_ITER:   max_iter_q   <= cfg_data[9:0];
				CFG_DAMPING:    damping_q    <= cfg_data[15:0];
				CFG_EPSILON:    epsilon_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			edge_total_q  <= '0;
			clr_idx_q     <= '0;
			idx_q         <= '0;
			eidx_q        <= '0;
			from_q        <= '0;
			dst_q         <= '0;
			iter_q        <= '0;
			first_q       <= 1'b0;
			uniform_q     <= '0;
			base_q        <= '0;
			err_q         <= '0;
			prod_hi_q     <= '0;
			prod_lo_q     <= '0;
			prev_q        <= '0;
			pend_status_q <= STAT_OK;
			pend_rank_q   <= '0;
			pend_iter_q   <= '0;
			pend_err_q    <= '0;
			pend_conv_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			out_status_q  <= STAT_OK;
			out_rank_q    <= '0;
			out_iter_q    <= '0;
			out_err_q     <= '0;
			out_conv_q    <= 1'b0;
		end else begin
			// ST_RESULT reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_RESULT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						pend_status_q <= STAT_OK;
						pend_rank_q   <= '0;
						pend_iter_q   <= '0;
						pend_err_q    <= '0;
						pend_conv_q   <= 1'b0;
						state_q       <= ST_RESULT;
						unique case (req_type)
							REQ_ADD_EDGE: begin
								if (!from_ok || !to_ok) begin
									pend_status_q <= STAT_RANGE;
								end else if (edge_total_q[ECNT_W-1]) begin
									pend_status_q <= STAT_FULL;
								end else begin
									edge_total_q <= edge_total_q + 1'b1;
									from_q       <= from_node;
									state_q      <= ST_EDGE_WR;
								end
							end
							REQ_RUN: begin
								if (!run_ok)
									pend_status_q <= STAT_RANGE;
								else
									state_q <= ST_DIV_U;
							end
							REQ_READ: begin
								if (!query_ok)
									pend_status_q <= STAT_RANGE;
								else
									state_q <= ST_READ_WAIT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE_WR: state_q <= ST_RESULT;
				ST_READ_WAIT: begin
					pend_rank_q <= rank_rdata;
					state_q     <= ST_RESULT;
				end
				ST_DIV_U: begin
					if (div_rsp.done) begin
						uniform_q <= uni_cap;
						state_q   <= ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (div_rsp.done) begin
						base_q  <= base_cap;
						iter_q  <= '0;
						first_q <= 1'b1;
						idx_q   <= '0;
						// no steps: ranks stay, result is all zero
						state_q <= (max_iter_q == '0) ? ST_RESULT : ST_C_RD;
					end
				end
				ST_C_RD: state_q <= ST_C_LD;
				ST_C_LD: begin
					if (deg_rdata != '0) begin
						state_q <= ST_C_DIV;
					end else if (last_node) begin
						eidx_q  <= '0;
						idx_q   <= '0;
						err_q   <= '0;
						state_q <= (edge_total_q == '0) ? ST_N_RD : ST_E_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_C_RD;
					end
				end
				ST_C_DIV: begin
					if (div_rsp.done) begin
						if (last_node) begin
							eidx_q  <= '0;
							idx_q   <= '0;
							err_q   <= '0;
							state_q <= (edge_total_q == '0) ? ST_N_RD : ST_E_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_C_RD;
						end
					end
				end
				ST_E_RD: state_q <= ST_E_CHK;
				ST_E_CHK: begin
					dst_q <= e_dst;
					if (e_ok) begin
						state_q <= ST_E_ACC;
					end else if (last_edge) begin
						state_q <= ST_N_RD;
					end else begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= ST_E_RD;
					end
				end
				ST_E_ACC: begin
					if (last_edge) begin
						state_q <= ST_N_RD;
					end else begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= ST_E_RD;
					end
				end
				ST_N_RD: state_q <= ST_N_MUL;
				ST_N_MUL: begin
					prod_hi_q <= damping_q * insum_rdata[SUM_W-1:16];
					prod_lo_q <= 16'((32'(damping_q) * 32'(insum_rdata[15:0])) >> 16);
					prev_q    <= c_prev;
					state_q   <= ST_N_ACC;
				end
				ST_N_ACC: begin
					err_q <= err_next;
					if (last_node) begin
						state_q <= ST_ITER_END;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_N_RD;
					end
				end
				ST_ITER_END: begin
					pend_iter_q <= iter_q + 1'b1;
					pend_err_q  <= err_q;
					if (err_q < {2'b00, epsilon_q}) begin
						pend_conv_q <= 1'b1;
						state_q     <= ST_RESULT;
					end else if (iter_q + 1'b1 == max_iter_q) begin
						state_q <= ST_RESULT;
					end else begin
						// new ranks in rank_mem serve as the previous ranks next step
						iter_q  <= iter_q + 1'b1;
						first_q <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_C_RD;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= pend_status_q;
						out_rank_q   <= pend_rank_q;
						out_iter_q   <= pend_iter_q;
						out_err_q    <= pend_err_q;
						out_conv_q   <= pend_conv_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign rank_value      = out_rank_q;
	assign iterations_done = out_iter_q;
	assign l1_error        = out_err_q;
	assign converged       = out_conv_q;

endmodule

>>> sv/prp_chk.sv
// Port-level checker for the PageRank engine, bound to the top level.
// Depends on prp_pkg for widths and status codes.
module prp_chk import prp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        status,
	input logic [RANK_W-1:0] rank_value,
	input logic [9:0]        iterations_done,
	input logic [L1_W-1:0]   l1_error,
	input logic              converged
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> rank_value == '0 && iterations_done == '0
			&& l1_error == '0 && !converged)
		else $error("error status carries payload");

	a_conv_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && converged |-> iterations_done != '0)
		else $error("converged with no steps");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_value != '0 |-> iterations_done == '0 && l1_error == '0
			&& !converged)
		else $error("rank read mixed with run fields");

endmodule

bind pagerank_power_iteration_top prp_chk u_prp_chk (.*);

>>> sim/testbench.sv
// Self-checking testbench for pagerank_power_iteration_top: edge loads, runs, rank reads.
// Depends on prp_pkg and the block's RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;
	import prp_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int EDGE_CAP = 65536;
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam longint unsigned RANK_TOP = 64'hFFFF_FFFF;
	localparam longint unsigned SUM_TOP = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned L1_TOP = 64'h3_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]      status;
		logic [RANK_W-1:0] rank_value;
		logic [9:0]      iterations_done;
		logic [L1_W-1:0] l1_error;
		logic            converged;
	} rank_result_t;

	class rank_scoreboard;
		int unsigned edge_src[EDGE_CAP];
		int unsigned edge_dst[EDGE_CAP];
		int unsigned edges_loaded;
		int unsigned degree[MAX_NODES];
		longint unsigned prev_rank[MAX_NODES];
		longint unsigned cur_rank[MAX_NODES];
		longint unsigned in_sum[MAX_NODES];
		int unsigned nodes_cfg, iter_cfg, damp_cfg;
		longint unsigned eps_cfg;
		rank_result_t expected_q[$];
		int mismatches;

		function new();
			edges_loaded = 0;
			foreach (degree[i]) degree[i] = 0;
			foreach (cur_rank[i]) cur_rank[i] = 0;
			nodes_cfg = 1;
			iter_cfg = 50;
			damp_cfg = 55706;
			eps_cfg = 4295;
			mismatches = 0;
		endfunction

		function longint unsigned sat_rank(longint unsigned v);
			return v > RANK_TOP ? RANK_TOP : v;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_NODE_COUNT: nodes_cfg = data[12:0];
				CFG_MAX_ITER:   iter_cfg = data[9:0];
				CFG_DAMPING:    damp_cfg = data[15:0];
				CFG_EPSILON:    eps_cfg = data;
			endcase
		endfunction

		function rank_result_t power_iterate();
			rank_result_t r;
			longint unsigned base, err, share, hi, lo, term, v, p, diff;
			int unsigned n, s, d, done;
			logic conv;
			r = '0;
			n = nodes_cfg;
			if (n == 0 || n > MAX_NODES) begin
				r.status = STAT_RANGE;
				return r;
			end
			for (int i = 0; i < n; i++) prev_rank[i] = sat_rank(64'h1_0000_0000 / n);
			base = sat_rank((longint'(65536 - damp_cfg) << 16) / n);
			err = 0;
			done = 0;
			conv = 0;
			for (int it = 0; it < iter_cfg; it++) begin
				for (int i = 0; i < n; i++) in_sum[i] = 0;
				for (int e = 0; e < edges_loaded; e++) begin
					s = edge_src[e];
					d = edge_dst[e];
					if (s >= n || d >= n || degree[s] == 0) continue;
					share = prev_rank[s] / degree[s];
					if (share > SUM_TOP - in_sum[d]) in_sum[d] = SUM_TOP;
					else in_sum[d] += share;
				end
				err = 0;
				for (int i = 0; i < n; i++) begin
					hi = in_sum[i] >> 16;
					lo = in_sum[i] & 64'hFFFF;
					term = damp_cfg * hi + ((damp_cfg * lo) >> 16);
					v = sat_rank(base + sat_rank(term));
					p = prev_rank[i];
					diff = v > p ? v - p : p - v;
					err = (diff > L1_TOP - err) ? L1_TOP : err + diff;
					cur_rank[i] = v;
				end
				done = it + 1;
				if (err < eps_cfg) begin
					conv = 1;
					break;
				end
				for (int i = 0; i < n; i++) prev_rank[i] = cur_rank[i];
			end
			r.iterations_done = 10'(done);
			r.l1_error = err[L1_W-1:0];
			r.converged = conv;
			return r;
		endfunction

		function void note_request(logic [1:0] kind, logic [11:0] src, logic [11:0] dst,
				logic [11:0] node);
			rank_result_t r;
			int unsigned lim;
			r = '0;
			lim = nodes_cfg < MAX_NODES ? nodes_cfg : MAX_NODES;
			case (kind)
				REQ_ADD_EDGE: begin
					if (src >= lim || dst >= lim) r.status = STAT_RANGE;
					else if (edges_loaded >= EDGE_CAP) r.status = STAT_FULL;
					else begin
						edge_src[edges_loaded] = src;
						edge_dst[edges_loaded] = dst;
						edges_loaded++;
						degree[src]++;
					end
				end
				REQ_RUN: r = power_iterate();
				REQ_READ: begin
					if (node >= lim) r.status = STAT_RANGE;
					else r.rank_value = cur_rank[node][31:0];
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(rank_result_t got);
			rank_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.rank_value !== want.rank_value ||
					got.iterations_done !== want.iterations_done ||
					got.l1_error !== want.l1_error || got.converged !== want.converged) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected %p, actual %p", $realtime, want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [NODE_W-1:0] from_node = '0, to_node = '0, query_node = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [RANK_W-1:0] rank_value;
	logic [9:0] iterations_done;
	logic [L1_W-1:0] l1_error;
	logic converged;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	rank_scoreboard sb = new();
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	bit hold_req = 0;
	int quiet_cycles = 0;

	pagerank_power_iteration_top u_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cycles = 400;
			hold_req = 0;
		end
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles--;
		end else
			out_stall <= ($urandom % 100) < stall_pct;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result('{status, rank_value, iterations_done, l1_error, converged});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] kind, logic [11:0] src, logic [11:0] dst,
			logic [11:0] node);
		if (($urandom % 100) < send_gap_pct) begin
			in_valid <= 0;
			do @(posedge clk); while (($urandom % 100) < send_gap_pct);
		end
		in_valid <= 1;
		req_type <= kind;
		from_node <= src;
		to_node <= dst;
		query_node <= node;
		do @(posedge clk); while (in_stall);
		sb.note_request(kind, src, dst, node);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_regs(int unsigned n, int unsigned iters, int unsigned damp,
			logic [31:0] eps);
		logic [31:0] vals[4];
		vals = '{n, iters, damp, eps};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(2'(i), vals[i]);
		end
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_phase(int items, int gap, int stall, bit long_hold);
		int unsigned n, pick;
		logic [31:0] eps;
		pick = $urandom % 4;
		eps = pick == 0 ? 32'd0 : pick == 1 ? $urandom_range(0, 5000) :
			pick == 2 ? $urandom : 32'hFFFF_FFFF;
		n = ($urandom % 4 == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		set_regs(n, $urandom_range(0, 5), $urandom % 65536, eps);
		send_gap_pct = gap;
		stall_pct = stall;
		if (long_hold) hold_req = 1;
		for (int k = 0; k < items; k++) begin
			// a stretch with no idling in the middle of each phase
			if (k == items / 2) begin
				send_gap_pct = 0;
				stall_pct = 0;
			end else if (k == items / 2 + 30) begin
				send_gap_pct = gap;
				stall_pct = stall;
			end
			pick = $urandom % 100;
			if (pick < 45) begin
				if (pick < 16)
					send_item(REQ_ADD_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						$urandom);
				else
					send_item(REQ_ADD_EDGE, $urandom, $urandom, $urandom);
			end else if (pick < 51)
				send_item(REQ_RUN, $urandom, $urandom, $urandom);
			else if (pick < 97) begin
				if (pick < 80)
					send_item(REQ_READ, $urandom, $urandom, $urandom_range(0, n + 1));
				else
					send_item(REQ_READ, $urandom, $urandom, $urandom);
			end else
				send_item(REQ_UNKNOWN, $urandom, $urandom, $urandom);
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: read before any run, single-node run saturates
		send_item(REQ_READ, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 12'hFFF);
		send_item(REQ_ADD_EDGE, 0, 0, 0);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 0);
		send_item(REQ_UNKNOWN, 12'hFFF, 12'hFFF, 12'hFFF);
		drain();

		// longest run: never converges with zero threshold
		set_regs(4, 1023, 65535, 0);
		send_item(REQ_ADD_EDGE, 0, 1, 0);
		send_item(REQ_ADD_EDGE, 1, 2, 0);
		send_item(REQ_ADD_EDGE, 2, 0, 0);
		send_item(REQ_ADD_EDGE, 1, 3, 0);
		send_item(REQ_ADD_EDGE, 2, 4, 0);
		send_item(REQ_RUN, 0, 0, 0);
		for (int i = 0; i < 4; i++) send_item(REQ_READ, 0, 0, i);
		drain();

		set_regs(0, 1, 0, 32'hFFFF_FFFF);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_ADD_EDGE, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 0);
		drain();
		set_regs(8191, 1, 0, 0);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 12'hFFF);
		drain();
		set_regs(MAX_NODES, 1, 0, 0);
		send_item(REQ_ADD_EDGE, 12'hFFF, 12'hFFF, 0);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 12'hFFF);
		drain();
		// node count lowered below loaded edge ends; zero iterations
		set_regs(3, 0, 55706, 4295);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 2);
		drain();
		set_regs(3, 3, 32768, 100);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 1);
		drain();

		random_phase(280, 0, 0, 0);
		random_phase(280, 47, 0, 0);
		random_phase(280, 0, 47, 1);
		random_phase(280, 20, 20, 0);
		random_phase(280, 47, 0, 0);

		// two-node graph, out-of-range edge end, zero-step run
		set_regs(2, 0, 65535, 0);
		send_gap_pct = 0;
		stall_pct = 0;
		send_item(REQ_ADD_EDGE, 0, 1, 0);
		send_item(REQ_ADD_EDGE, 1, 1, 0);
		send_item(REQ_ADD_EDGE, 5, 0, 0);
		send_item(REQ_RUN, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 1);
		drain();

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
